FILE: rtl/odo_pkg.sv
// Shared types, constants and helper functions for the differential-drive odometry block.
package odo_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 24;

   // CORDIC angle register (Q32 radians) and vector register (Q30) widths.
   localparam int ZW = 37;
   localparam int VW = 34;

   // Shared multiply-accumulate unit widths.
   localparam int MAC_A_W = 33;
   localparam int MAC_B_W = 17;
   localparam int MAC_P_W = MAC_A_W + MAC_B_W;
   localparam int ACC_W   = 82;

   localparam logic signed [ZW-1:0] PI_Q32      = 37'sd13493037705;
   localparam logic signed [ZW-1:0] HALF_PI_Q32 = 37'sd6746518852;
   localparam logic signed [ZW-1:0] TWO_PI_Q32  = 37'sd26986075409;
   localparam logic signed [VW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic signed [63:0] WRAP_PI_Q28     = 64'sd843314681;
   localparam logic signed [63:0] WRAP_TWO_PI_Q28 = 64'sd1686629362;

   localparam logic [31:0] DPC_RESET = 32'd3635623;
   localparam logic [31:0] RPC_RESET = 32'd10724555;

   // Left shift applied to a partial product before it joins the accumulator.
   localparam logic [1:0] SHIFT_0  = 2'd0;
   localparam logic [1:0] SHIFT_16 = 2'd1;
   localparam logic [1:0] SHIFT_32 = 2'd2;

   typedef struct packed {
      logic       issue;
      logic       first;
      logic [1:0] shift;
   } mac_ctrl_type;

   // atan(2^-i) in Q32 radians.
   function automatic logic [31:0] atan_q32(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd3373259426;
         5'd1:  r = 32'd1991351318;
         5'd2:  r = 32'd1052175346;
         5'd3:  r = 32'd534100635;
         5'd4:  r = 32'd268086748;
         5'd5:  r = 32'd134174063;
         5'd6:  r = 32'd67103403;
         5'd7:  r = 32'd33553749;
         5'd8:  r = 32'd16777131;
         5'd9:  r = 32'd8388597;
         5'd10: r = 32'd4194303;
         5'd11: r = 32'd2097152;
         5'd12: r = 32'd1048576;
         5'd13: r = 32'd524288;
         5'd14: r = 32'd262144;
         5'd15: r = 32'd131072;
         5'd16: r = 32'd65536;
         5'd17: r = 32'd32768;
         5'd18: r = 32'd16384;
         5'd19: r = 32'd8192;
         5'd20: r = 32'd4096;
         5'd21: r = 32'd2048;
         5'd22: r = 32'd1024;
         5'd23: r = 32'd512;
         5'd24: r = 32'd256;
         5'd25: r = 32'd128;
         5'd26: r = 32'd64;
         5'd27: r = 32'd32;
         5'd28: r = 32'd16;
         5'd29: r = 32'd8;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer, pose state and ports.
// An input beat passes through the distance and heading products, the iterative CORDIC and
// six passes through the single multiply-accumulate unit for the position terms. A new beat
// is taken only once the block is idle again, after the previous result has been stored.
// Reset (synchronous): pose and previous counts clear to zero, registers take their defaults.
module diff_drive_odometry #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // right_count [31:0], left_count [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x [31:0], pos_y [63:32], heading [95:64]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_TRIG = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [31:0]        dpc_ff, dpc_in;
   logic [31:0]        rpc_ff, rpc_in;
   logic [31:0]        prev_right_ff, prev_right_in;
   logic [31:0]        prev_left_ff, prev_left_in;
   logic signed [31:0] x_acc_ff, x_acc_in;
   logic signed [31:0] y_acc_ff, y_acc_in;
   logic signed [31:0] head_acc_ff, head_acc_in;
   logic signed [32:0] sum_ff, sum_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [48:0] dist_ff, dist_in;
   logic signed [63:0] nh_ff, nh_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic                                accept;
   logic                                csr_write;
   logic [31:0]                         dr, dl;
   logic                                cordic_done;
   logic signed [odo_pkg::MAC_A_W-1:0]  cordic_cos, cordic_sin;
   odo_pkg::mac_ctrl_type               mac_ctrl;
   logic signed [odo_pkg::MAC_A_W-1:0]  mac_a;
   logic signed [odo_pkg::MAC_B_W-1:0]  mac_b;
   logic signed [odo_pkg::ACC_W-1:0]    mac_acc;
   logic signed [63:0]                  pos_sum;
   logic signed [63:0]                  nh_wrapped;
   logic signed [31:0]                  head_new;
   logic                                out_free;

   assign accept    = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign dr        = req_tdata[31:0] - prev_right_ff;
   assign dl        = req_tdata[63:32] - prev_left_ff;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   // The distance term is split into two unsigned 16 bit digits and a signed top digit.
   always_comb begin
      mac_ctrl = '{issue: 1'b0, first: 1'b0, shift: odo_pkg::SHIFT_0};
      mac_a    = sum_ff;
      mac_b    = {1'b0, dpc_ff[15:0]};
      if (state_ff == S_MUL) begin
         case (phase_ff)
            3'd0: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b1, shift: odo_pkg::SHIFT_0};
            end
            3'd1: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_16};
               mac_b    = {1'b0, dpc_ff[31:16]};
            end
            3'd2: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b1, shift: odo_pkg::SHIFT_0};
               mac_a    = diff_ff;
               mac_b    = {1'b0, rpc_ff[15:0]};
            end
            3'd3: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_16};
               mac_a    = diff_ff;
               mac_b    = {1'b0, rpc_ff[31:16]};
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_TRIG) begin
         case (phase_ff)
            3'd0: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b1, shift: odo_pkg::SHIFT_0};
               mac_a    = cordic_cos;
               mac_b    = {1'b0, dist_ff[15:0]};
            end
            3'd1: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_16};
               mac_a    = cordic_cos;
               mac_b    = {1'b0, dist_ff[31:16]};
            end
            3'd2: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_32};
               mac_a    = cordic_cos;
               mac_b    = dist_ff[48:32];
            end
            3'd3: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b1, shift: odo_pkg::SHIFT_0};
               mac_a    = cordic_sin;
               mac_b    = {1'b0, dist_ff[15:0]};
            end
            3'd4: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_16};
               mac_a    = cordic_sin;
               mac_b    = {1'b0, dist_ff[31:16]};
            end
            3'd5: begin
               mac_ctrl = '{issue: 1'b1, first: 1'b0, shift: odo_pkg::SHIFT_32};
               mac_a    = cordic_sin;
               mac_b    = dist_ff[48:32];
            end
            default: begin
            end
         endcase
      end
   end

   // The accumulator is read after the last product of a group has passed the product and accumulator registers.
   assign pos_sum = (state_ff == S_TRIG && phase_ff == 3'd4)
                  ? {{32{x_acc_ff[31]}}, x_acc_ff} + {{12{mac_acc[81]}}, mac_acc[81:30]}
                  : {{32{y_acc_ff[31]}}, y_acc_ff} + {{12{mac_acc[81]}}, mac_acc[81:30]};

   always_comb begin
      if (nh_ff > odo_pkg::WRAP_PI_Q28) begin
         nh_wrapped = nh_ff - odo_pkg::WRAP_TWO_PI_Q28;
      end else if (nh_ff <= -odo_pkg::WRAP_PI_Q28) begin
         nh_wrapped = nh_ff + odo_pkg::WRAP_TWO_PI_Q28;
      end else begin
         nh_wrapped = nh_ff;
      end
   end

   assign head_new = odo_pkg::sat_to_32(nh_wrapped);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      dpc_in        = dpc_ff;
      rpc_in        = rpc_ff;
      prev_right_in = prev_right_ff;
      prev_left_in  = prev_left_ff;
      x_acc_in      = x_acc_ff;
      y_acc_in      = y_acc_ff;
      head_acc_in   = head_acc_ff;
      sum_in        = sum_ff;
      diff_in       = diff_ff;
      dist_in       = dist_ff;
      nh_in         = nh_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_write) begin
         if (csr_paddr[2]) begin
            rpc_in = csr_pwdata;
         end else begin
            dpc_in = csr_pwdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sum_in        = {dr[31], dr} + {dl[31], dl};
               diff_in       = {dr[31], dr} - {dl[31], dl};
               prev_right_in = req_tdata[31:0];
               prev_left_in  = req_tdata[63:32];
               phase_in      = '0;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            if (phase_ff == 3'd3) begin
               dist_in = mac_acc[65:17];
            end
            if (phase_ff == 3'd5) begin
               nh_in    = {{32{head_acc_ff[31]}}, head_acc_ff} + mac_acc[67:4];
               phase_in = '0;
               state_in = S_WAIT;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         S_WAIT: begin
            if (cordic_done) begin
               phase_in = '0;
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            if (phase_ff == 3'd4) begin
               x_acc_in = odo_pkg::sat_to_32(pos_sum);
            end
            if (phase_ff == 3'd7) begin
               y_acc_in = odo_pkg::sat_to_32(pos_sum);
               state_in = S_DONE;
            end
            phase_in = phase_ff + 1'b1;
         end
         S_DONE: begin
            // Hold the new pose back until the previous result beat has left.
            if (out_free) begin
               head_acc_in   = head_new;
               rsp_data_in   = {head_new, y_acc_ff, x_acc_ff};
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= '0;
         dpc_ff        <= odo_pkg::DPC_RESET;
         rpc_ff        <= odo_pkg::RPC_RESET;
         prev_right_ff <= '0;
         prev_left_ff  <= '0;
         x_acc_ff      <= '0;
         y_acc_ff      <= '0;
         head_acc_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         dpc_ff        <= dpc_in;
         rpc_ff        <= rpc_in;
         prev_right_ff <= prev_right_in;
         prev_left_ff  <= prev_left_in;
         x_acc_ff      <= x_acc_in;
         y_acc_ff      <= y_acc_in;
         head_acc_ff   <= head_acc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      dist_ff     <= dist_in;
      nh_ff       <= nh_in;
      rsp_data_ff <= rsp_data_in;
   end

   odo_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .angle  (head_acc_ff),
      .done   (cordic_done),
      .cosine (cordic_cos),
      .sine   (cordic_sin)
   );

   odo_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (mac_acc)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_prdata = csr_paddr[2] ? rpc_ff : dpc_ff;
   assign csr_pready = 1'b1;

   a_trig_after_cordic: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRIG |-> cordic_done)
      else $error("position products issued before the CORDIC finished");

   a_cordic_restarts: assert property (@(posedge clock) disable iff (reset)
      accept |=> !cordic_done)
      else $error("CORDIC result of a previous beat still flagged after a new beat");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside the completion step");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_tvalid_ff && !rsp_tready |=> state_ff == S_DONE)
      else $error("pending result beat overwritten");

endmodule

FILE: rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine (Q30) of a Q4.28 heading.
module odo_cordic #(
   parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [31:0]                  angle,
   output logic                                done,
   output logic signed [odo_pkg::MAC_A_W-1:0]  cosine,
   output logic signed [odo_pkg::MAC_A_W-1:0]  sine
);

   localparam int StepW = $clog2(CORDIC_STEPS);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_FOLD = 2'd1;
   localparam logic [1:0] C_ITER = 2'd2;
   localparam logic [1:0] C_DONE = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [StepW-1:0]              step_ff, step_in;
   logic signed [odo_pkg::ZW-1:0] z_ff, z_in;
   logic signed [odo_pkg::VW-1:0] x_ff, x_in;
   logic signed [odo_pkg::VW-1:0] y_ff, y_in;
   logic                          neg_ff, neg_in;

   logic signed [odo_pkg::ZW-1:0] z_start;
   logic signed [odo_pkg::ZW-1:0] atan_ext;
   logic signed [odo_pkg::VW-1:0] x_shr, y_shr;
   logic signed [odo_pkg::VW-1:0] cos_full, sin_full;

   assign z_start  = {angle[31], angle, 4'b0000};
   assign atan_ext = {5'b00000, odo_pkg::atan_q32(5'(step_ff))};
   assign x_shr    = x_ff >>> step_ff;
   assign y_shr    = y_ff >>> step_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      if (start) begin
         // First bring the angle into the range -pi to pi.
         if (z_start > odo_pkg::PI_Q32) begin
            z_in = z_start - odo_pkg::TWO_PI_Q32;
         end else if (z_start < -odo_pkg::PI_Q32) begin
            z_in = z_start + odo_pkg::TWO_PI_Q32;
         end else begin
            z_in = z_start;
         end
         x_in     = odo_pkg::CORDIC_GAIN_Q30;
         y_in     = '0;
         neg_in   = 1'b0;
         step_in  = '0;
         state_in = C_FOLD;
      end else begin
         case (state_ff)
            C_FOLD: begin
               // Fold into the right half plane; the results are negated at the end.
               if (z_ff > odo_pkg::HALF_PI_Q32) begin
                  z_in   = z_ff - odo_pkg::PI_Q32;
                  neg_in = 1'b1;
               end else if (z_ff < -odo_pkg::HALF_PI_Q32) begin
                  z_in   = z_ff + odo_pkg::PI_Q32;
                  neg_in = 1'b1;
               end
               state_in = C_ITER;
            end
            C_ITER: begin
               if (z_ff >= 0) begin
                  x_in = x_ff - y_shr;
                  y_in = y_ff + x_shr;
                  z_in = z_ff - atan_ext;
               end else begin
                  x_in = x_ff + y_shr;
                  y_in = y_ff - x_shr;
                  z_in = z_ff + atan_ext;
               end
               if (step_ff == StepW'(CORDIC_STEPS - 1)) begin
                  state_in = C_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      z_ff   <= z_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      neg_ff <= neg_in;
   end

   assign cos_full = neg_ff ? -x_ff : x_ff;
   assign sin_full = neg_ff ? -y_ff : y_ff;
   assign cosine   = cos_full[odo_pkg::MAC_A_W-1:0];
   assign sine     = sin_full[odo_pkg::MAC_A_W-1:0];
   assign done     = (state_ff == C_DONE);

endmodule

FILE: rtl/odo_mac.sv
// Shared signed multiply-accumulate unit with a registered product and shifted accumulation.
module odo_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  odo_pkg::mac_ctrl_type               ctrl,
   input  logic signed [odo_pkg::MAC_A_W-1:0]  a,
   input  logic signed [odo_pkg::MAC_B_W-1:0]  b,
   output logic signed [odo_pkg::ACC_W-1:0]    acc
);

   localparam int ExtW = odo_pkg::ACC_W - odo_pkg::MAC_P_W;

   logic signed [odo_pkg::MAC_P_W-1:0] product_ff, product_in;
   logic                               pend_ff;
   logic                               first_ff;
   logic [1:0]                         shift_ff;
   logic signed [odo_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [odo_pkg::ACC_W-1:0]   product_ext;
   logic signed [odo_pkg::ACC_W-1:0]   addend;

   assign product_in  = a * b;
   assign product_ext = {{ExtW{product_ff[odo_pkg::MAC_P_W-1]}}, product_ff};

   always_comb begin
      case (shift_ff)
         odo_pkg::SHIFT_16: addend = product_ext <<< 16;
         odo_pkg::SHIFT_32: addend = product_ext <<< 32;
         default:           addend = product_ext;
      endcase
      if (!pend_ff) begin
         acc_in = acc_ff;
      end else if (first_ff) begin
         acc_in = addend;
      end else begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctrl.issue;
      end
      first_ff   <= ctrl.first;
      shift_ff   <= ctrl.shift;
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: dv/diff_drive_odometry_tb.sv
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps

module diff_drive_odometry_tb;

   localparam int STEPS      = odo_pkg::CORDIC_STEPS_DEFAULT;
   localparam int LATENCY    = STEPS + 11;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD  = 600;

   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint PI_Q32       = 64'sd13493037705;
   localparam longint HALF_PI_Q32  = 64'sd6746518852;
   localparam longint TWO_PI_Q32   = 64'sd26986075409;
   localparam longint PI_Q28       = 64'sd843314681;
   localparam longint TWO_PI_Q28   = 64'sd1686629362;
   localparam logic [31:0] DPC_DEFAULT = 32'd3635623;
   localparam logic [31:0] RPC_DEFAULT = 32'd10724555;

   typedef enum int {
      REG_DPC = 0,
      REG_RPC = 1
   } csr_reg_type;

   typedef struct {
      logic [31:0] right;
      logic [31:0] left;
      bit          drain;
   } count_pair_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] hdg;
   } pose_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // right_count [31:0], left_count [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;       // pos_x [31:0], pos_y [63:32], heading [95:64]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   diff_drive_odometry #(
      .CORDIC_STEPS(STEPS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Odometry state as the block should hold it.
   logic [31:0]        dist_per_count;
   logic [31:0]        rad_per_count;
   logic [31:0]        prev_right;
   logic [31:0]        prev_left;
   logic signed [31:0] x_acc;
   logic signed [31:0] y_acc;
   logic signed [31:0] head_acc;

   longint atan_tab [0:29] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
      64'sd16777131, 64'sd8388597, 64'sd4194303, 64'sd2097152,
      64'sd1048576, 64'sd524288, 64'sd262144, 64'sd131072,
      64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
      64'sd4096, 64'sd2048, 64'sd1024, 64'sd512,
      64'sd256, 64'sd128, 64'sd64, 64'sd32, 64'sd16, 64'sd8
   };

   count_pair_type count_q[$];
   pose_type       pose_q[$];
   count_pair_type cur_pair;
   int          beats_queued = 0;
   int          beats_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   int          send_gap = 0;
   int          send_calm = 0;
   int          ready_stall = 0;
   int          ready_calm = 0;
   int          hold_left = 0;
   bit          long_hold_done = 1'b0;
   int          quiet_cycles = 0;
   logic [31:0] gen_r = '0;
   logic [31:0] gen_l = '0;

   function automatic void clear_pose();
      dist_per_count = DPC_DEFAULT;
      rad_per_count  = RPC_DEFAULT;
      prev_right = '0;
      prev_left  = '0;
      x_acc = '0;
      y_acc = '0;
      head_acc = '0;
   endfunction

   function automatic longint sat_q(input longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   // Cosine and sine in Q30 of a Q4.28 angle, folded into the CORDIC's range first.
   function automatic void cordic_trig(input logic signed [31:0] ang,
                                       output longint c, output longint s);
      longint z, vx, vy, nx;
      bit     flip;
      int     i;
      z = longint'(ang) * 16;
      vx = GAIN_Q30;
      vy = 0;
      flip = 1'b0;
      if (z > PI_Q32)
         z -= TWO_PI_Q32;
      else if (z < -PI_Q32)
         z += TWO_PI_Q32;
      if (z > HALF_PI_Q32) begin
         z -= PI_Q32;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q32) begin
         z += PI_Q32;
         flip = 1'b1;
      end
      for (i = 0; i < STEPS && i < 30; i++) begin
         if (z >= 0) begin
            nx = vx - (vy >>> i);
            vy = vy + (vx >>> i);
            z -= atan_tab[i];
         end else begin
            nx = vx + (vy >>> i);
            vy = vy - (vx >>> i);
            z += atan_tab[i];
         end
         vx = nx;
      end
      c = flip ? -vx : vx;
      s = flip ? -vy : vy;
   endfunction

   // Distance is split into high and low halves so that the product stays within 64 bits.
   function automatic longint scale_trig(input longint d, input longint c);
      longint dh, dlow;
      dh = d >>> 16;
      dlow = d - dh * 65536;
      return (dh * c + ((dlow * c) >>> 16)) >>> 14;
   endfunction

   function automatic pose_type advance_pose(input logic [31:0] r, input logic [31:0] l);
      logic [31:0] dr32, dl32;
      longint      dr, dl, sum, diff, dhi, dlo, rhi, rlo, travel, dhead, nh, cs, sn;
      pose_type    p;
      dr32 = r - prev_right;
      dl32 = l - prev_left;
      dr = longint'($signed(dr32));
      dl = longint'($signed(dl32));
      sum = dr + dl;
      diff = dr - dl;
      dhi = dist_per_count >> 16;
      dlo = dist_per_count & 32'h0000ffff;
      rhi = rad_per_count >> 16;
      rlo = rad_per_count & 32'h0000ffff;
      travel = (sum * dhi + ((sum * dlo) >>> 16)) >>> 1;
      dhead = diff * rhi * 4096 + ((diff * rlo) >>> 4);
      cordic_trig(head_acc, cs, sn);
      x_acc = 32'(sat_q(longint'(x_acc) + scale_trig(travel, cs)));
      y_acc = 32'(sat_q(longint'(y_acc) + scale_trig(travel, sn)));
      // The heading is wrapped once only; a huge turn then saturates.
      nh = longint'(head_acc) + dhead;
      if (nh > PI_Q28)
         nh -= TWO_PI_Q28;
      else if (nh <= -PI_Q28)
         nh += TWO_PI_Q28;
      head_acc = 32'(sat_q(nh));
      prev_right = r;
      prev_left = l;
      p.x = x_acc;
      p.y = y_acc;
      p.hdg = head_acc;
      return p;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         send_calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic int pick_stall();
      int roll;
      if (ready_calm > 0) begin
         ready_calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         ready_calm = $urandom_range(30, 150);
         return 0;
      end
      if (roll < 70)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // Mostly small, plausible wheel movements; some jumps, repeats and counts near the wrap.
   function automatic void next_counts();
      int roll, dr, dl;
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
         dr = int'($urandom_range(0, 600)) - 300;
         dl = dr + int'($urandom_range(0, 120)) - 60;
         gen_r += dr;
         gen_l += dl;
      end else if (roll < 78) begin
         gen_r += int'($urandom_range(0, 131072)) - 65536;
         gen_l += int'($urandom_range(0, 131072)) - 65536;
      end else if (roll < 90) begin
         gen_r = $urandom();
         gen_l = $urandom();
      end else if (roll < 95) begin
         gen_r = gen_r;
      end else begin
         gen_r = ($urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffc0) + $urandom_range(0, 63);
         gen_l = ($urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffc0) + $urandom_range(0, 63);
      end
   endfunction

   function automatic void push_counts(input logic [31:0] r, input logic [31:0] l,
                                       input bit drain);
      count_pair_type c;
      c.right = r;
      c.left = l;
      c.drain = drain;
      count_q.push_back(c);
      beats_queued++;
   endfunction

   function automatic void queue_random(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         next_counts();
         push_counts(gen_r, gen_l, $urandom_range(0, 149) == 0);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endfunction

   // Input driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pose_q.push_back(advance_pose(cur_pair.right, cur_pair.left));
            beats_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (count_q.size() > 0 && (!count_q[0].drain || pose_q.size() == 0)) begin
               cur_pair = count_q.pop_front();
               req_tdata <= {cur_pair.left, cur_pair.right};
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pose_q.size() == 0) begin
               $error("unexpected result beat: pos_x %0d, pos_y %0d, heading %0d",
                      $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                      $signed(rsp_tdata[95:64]));
               mismatches++;
            end else begin
               pose_type want;
               want = pose_q.pop_front();
               check_field("pos_x", want.x, rsp_tdata[31:0]);
               check_field("pos_y", want.y, rsp_tdata[63:32]);
               check_field("heading", want.hdg, rsp_tdata[95:64]);
            end
         end
         // One long hold-off while the sender keeps offering beats, so the input backs up.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 250) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (ready_stall > 0) begin
            ready_stall--;
            rsp_tready <= 1'b0;
         end else begin
            ready_stall = pick_stall();
            rsp_tready <= (ready_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_register(input csr_reg_type idx, input logic [31:0] value);
      logic [31:0] rd;
      logic [2:0]  addr;
      addr = 3'(int'(idx) * 4);
      csr_access(1'b1, addr, value, rd);
      if (idx == REG_DPC)
         dist_per_count = value;
      else
         rad_per_count = value;
      csr_access(1'b0, addr, '0, rd);
      check_field(idx == REG_DPC ? "distance_per_count" : "radians_per_count", value, rd);
   endtask

   // Waits until every beat has gone in and every result has come back, then lets the
   // pipeline settle for its latency.
   task automatic wait_drained();
      while (beats_sent != beats_queued || pose_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] dpc, input logic [31:0] rpc, input int n);
      wait_drained();
      set_register(REG_DPC, dpc);
      set_register(REG_RPC, rpc);
      queue_random(n);
   endtask

   initial begin
      clear_pose();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats with the reset register values.
      push_counts(32'd0, 32'd0, 1'b0);
      push_counts(32'd100, 32'd100, 1'b0);
      push_counts(32'd200, 32'd150, 1'b0);
      push_counts(32'd150, 32'd200, 1'b0);
      push_counts(-32'sd1000, -32'sd1000, 1'b0);
      push_counts(32'h7fffffff, 32'h7fffffff, 1'b0);
      push_counts(32'h80000000, 32'h80000000, 1'b0);
      push_counts(32'h80000000, 32'h7fffffff, 1'b0);
      push_counts(32'hffffffff, 32'h00000000, 1'b0);
      push_counts(32'h00000000, 32'hffffffff, 1'b1);
      // Opposite extremes give a turn far beyond one wrap, leaving the heading saturated.
      push_counts(32'h7fffffff, 32'h80000000, 1'b0);
      push_counts(32'h7fffffff, 32'h80000000, 1'b0);
      push_counts(32'h80000000, 32'h7fffffff, 1'b0);
      push_counts(32'd0, 32'd0, 1'b0);
      gen_r = '0;
      gen_l = '0;
      // Steady turning that carries the heading round all four quadrants.
      for (int k = 0; k < 10; k++) begin
         gen_r += 500;
         gen_l += 100;
         push_counts(gen_r, gen_l, 1'b0);
      end
      queue_random(480);
      // Force at least one pause of the sender until all results are back.
      push_counts(gen_r, gen_l, 1'b1);

      run_phase(32'd0, 32'd0, 80);
      run_phase(32'hffffffff, 32'hffffffff, 150);
      run_phase($urandom(), $urandom(), 250);
      run_phase(32'h00010000, 32'h00400000, 300);
      run_phase(32'h00000001, 32'h80000000, 100);
      run_phase(DPC_DEFAULT, RPC_DEFAULT, 400);
      wait_drained();

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/odo_pkg.sv
rtl/odo_cordic.sv
rtl/odo_mac.sv
rtl/diff_drive_odometry.sv
dv/diff_drive_odometry_tb.sv
